// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 32;
	localparam int MEDIAN_W   = 33;
	localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEDIAN_W-1:0] median_t;
	typedef logic        [COUNT_W-1:0]  count_t;

	typedef struct packed {
		logic del;
		logic below;
		logic gt;
	} cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
	parameter int AW = 6
) (
	input  wire                  clk,
	input  wire                  step,
	input  swm_pkg::sample_t     x,
	input  wire                  full,
	input  wire                  cell_valid,
	input  wire  [AW-1:0]        win_last,
	input  wire                  below_del,
	input  swm_pkg::sample_t     lower_val,
	input  wire  [AW-1:0]        lower_age,
	input  swm_pkg::cell_flags_t lower_flags,
	input  swm_pkg::sample_t     upper_val,
	input  wire  [AW-1:0]        upper_age,
	input  swm_pkg::cell_flags_t upper_flags,
	output swm_pkg::sample_t     val_q,
	output logic [AW-1:0]        age_q,
	output swm_pkg::cell_flags_t flags
);
	import swm_pkg::*;

	logic    del;
	logic    gt;
	sample_t val_d;
	logic [AW-1:0] age_d;

	assign del = full && cell_valid && (age_q == win_last);
	assign gt  = !cell_valid || (val_q > x);

	assign flags = '{del: del, below: below_del, gt: gt};

	always_comb begin
		if (!upper_flags.del && upper_flags.below && !upper_flags.gt) begin
			val_d = upper_val;
			age_d = upper_age + AW'(1);
		end else if (!del && (below_del == gt)) begin
			val_d = val_q;
			age_d = age_q + AW'(1);
		end else if (!lower_flags.del && !lower_flags.below && lower_flags.gt) begin
			val_d = lower_val;
			age_d = lower_age + AW'(1);
		end else begin
			val_d = x;
			age_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sliding window median filter.
// Input channel: in_valid / in_stall with one signed 32-bit sample per transfer.
// Output channel: out_valid / out_stall with median_doubled (twice the median,
// sum of the two middle samples for an even count) and held_count.
// Config channel: cfg_valid / cfg_ready with window_size; cfg_ready is always
// high. A write empties the window; 0 acts as 1, values above WINDOW_MAX
// act as WINDOW_MAX. Write only while no result is outstanding.
// The samples sit in a row of WINDOW_MAX sorted cells; each transfer removes
// the oldest sample (once the window is full) and inserts the new one in the
// same update, every cell loading from itself, a neighbor or the new sample.
// An input transfer sets a pending flag; the result then moves into the output
// register, raising out_valid, once that register is empty or its result
// transfers. Throughput: one sample per cycle while in_stall is low; the
// median select plus add sits in the output register stage after the cell row.
// Reset empties the window and sets the window to 64 (or WINDOW_MAX if less).
// When the receiver stalls, the result holds in the output register, at most
// one more sample is taken into the cell row, then in_stall rises until the
// output transfer completes.
module sliding_window_median (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  swm_pkg::sample_t  sample,
	output logic              out_valid,
	input  wire               out_stall,
	output swm_pkg::median_t  median_doubled,
	output swm_pkg::count_t   held_count,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  swm_pkg::count_t   window_size
);
	import swm_pkg::*;

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int RST_WIN = (WINDOW_MAX < 64) ? WINDOW_MAX : 64;

	logic [CW-1:0] win_q;
	logic [CW-1:0] count_q;
	logic          pend_s1;
	logic          out_valid_q;
	median_t       median_q;
	count_t        held_q;

	logic          in_xfer;
	logic          cfg_xfer;
	logic          full;
	logic [AW-1:0] win_last;
	logic [CW-1:0] win_d;

	sample_t       cell_val [WINDOW_MAX];
	logic [AW-1:0] cell_age [WINDOW_MAX];
	cell_flags_t   cell_flg [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] del_vec;
	logic [WINDOW_MAX-1:0] below_vec;
	logic [WINDOW_MAX-1:0] valid_vec;

	logic [AW-1:0] idx_hi;
	logic [AW-1:0] idx_lo;
	sample_t       mid_lo;
	sample_t       mid_hi;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign in_stall  = pend_s1 && out_valid_q && out_stall;
	assign in_xfer   = in_valid && !in_stall;
	assign full      = (count_q >= win_q);
	assign win_last  = AW'(win_q - CW'(1));

	always_comb begin
		if (window_size == '0) begin
			win_d = CW'(1);
		end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
			win_d = CW'(WINDOW_MAX);
		end else begin
			win_d = CW'(window_size);
		end
	end

	genvar k;
	generate
		for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
			sample_t       lo_val;
			logic [AW-1:0] lo_age;
			cell_flags_t   lo_flg;
			sample_t       up_val;
			logic [AW-1:0] up_age;
			cell_flags_t   up_flg;

			assign del_vec[k]   = cell_flg[k].del;
			assign valid_vec[k] = (count_q > CW'(k));

			if (k == 0) begin : g_first
				assign below_vec[k] = 1'b0;
				assign lo_val = '0;
				assign lo_age = '0;
				assign lo_flg = '{del: 1'b0, below: 1'b0, gt: 1'b0};
			end else begin : g_mid_lo
				assign below_vec[k] = |del_vec[k-1:0];
				assign lo_val = cell_val[k-1];
				assign lo_age = cell_age[k-1];
				assign lo_flg = cell_flg[k-1];
			end

			if (k == WINDOW_MAX - 1) begin : g_last
				assign up_val = '0;
				assign up_age = '0;
				assign up_flg = '{del: 1'b0, below: 1'b0, gt: 1'b1};
			end else begin : g_mid_up
				assign up_val = cell_val[k+1];
				assign up_age = cell_age[k+1];
				assign up_flg = cell_flg[k+1];
			end

			swm_cell #(
				.AW(AW)
			) u_cell (
				.clk         (clk),
				.step        (in_xfer),
				.x           (sample),
				.full        (full),
				.cell_valid  (valid_vec[k]),
				.win_last    (win_last),
				.below_del   (below_vec[k]),
				.lower_val   (lo_val),
				.lower_age   (lo_age),
				.lower_flags (lo_flg),
				.upper_val   (up_val),
				.upper_age   (up_age),
				.upper_flags (up_flg),
				.val_q       (cell_val[k]),
				.age_q       (cell_age[k]),
				.flags       (cell_flg[k])
			);
		end
	endgenerate

	assign idx_hi = AW'(count_q >> 1);
	assign idx_lo = count_q[0] ? idx_hi : (idx_hi - AW'(1));

	always_comb begin
		mid_lo = '0;
		mid_hi = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (AW'(i) == idx_lo) begin
				mid_lo = cell_val[i];
			end
			if (AW'(i) == idx_hi) begin
				mid_hi = cell_val[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= CW'(RST_WIN);
			count_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				win_q   <= win_d;
				count_q <= '0;
			end else if (in_xfer && !full) begin
				count_q <= count_q + CW'(1);
			end

			if (pend_s1 && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (in_xfer) begin
				pend_s1 <= 1'b1;
			end else if (!out_valid_q || !out_stall) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1 && (!out_valid_q || !out_stall)) begin
			median_q <= {mid_lo[SAMPLE_W-1], mid_lo} + {mid_hi[SAMPLE_W-1], mid_hi};
			held_q   <= COUNT_W'(count_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign median_doubled = median_q;
	assign held_count     = held_q;

	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= win_q)
		else $error("count exceeds window");

	a_single_removal: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(del_vec))
		else $error("more than one cell removed");

	a_removal_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && full && count_q != '0) |-> (del_vec != '0))
		else $error("full window without oldest cell");

	a_pending_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && !out_valid_q) |=> out_valid_q)
		else $error("pending result not moved to output");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (held_q != '0))
		else $error("result with empty window");

endmodule

`default_nettype wire

// ===== test/sliding_window_median_test.sv =====
`timescale 1ns / 1ps

module sliding_window_median_test;
	import swm_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam sample_t SAMPLE_MAX = 32'sh7fffffff;
	localparam sample_t SAMPLE_MIN = 32'sh80000000;
	localparam count_t WINDOW_RESET = count_t'((WINDOW_MAX < 64) ? WINDOW_MAX : 64);

	typedef struct {
		median_t median;
		count_t  count;
	} median_result_t;

	class window_median_tracker;
		count_t window;
		sample_t arrival[WINDOW_MAX];
		sample_t ordered[WINDOW_MAX];
		int unsigned oldest;
		int unsigned held;
		median_result_t expected_q[$];
		int failures;

		function new();
			window = WINDOW_RESET;
			oldest = 0;
			held = 0;
			failures = 0;
		endfunction

		function void set_window(count_t v);
			window = v;
			oldest = 0;
			held = 0;
		endfunction

		function int unsigned span();
			int unsigned w;
			w = 32'(window);
			if (w == 0)
				w = 1;
			if (w > WINDOW_MAX)
				w = WINDOW_MAX;
			return w;
		endfunction

		function void take_sample(sample_t s);
			int unsigned w;
			int unsigned p;
			int unsigned i;
			sample_t gone;
			median_result_t r;
			w = span();
			if (oldest >= w)
				oldest = 0;
			if (held >= w) begin
				// drop one sorted entry equal to the oldest sample
				gone = arrival[oldest];
				p = 0;
				while (p < held && ordered[p] != gone)
					p++;
				if (p < held) begin
					for (i = p; i + 1 < held; i++)
						ordered[i] = ordered[i + 1];
					held--;
				end
				arrival[oldest] = s;
				oldest = (oldest + 1) % w;
			end else begin
				arrival[(oldest + held) % w] = s;
			end
			if (held < WINDOW_MAX) begin
				p = 0;
				while (p < held && ordered[p] <= s)
					p++;
				for (i = held; i > p; i--)
					ordered[i] = ordered[i - 1];
				ordered[p] = s;
				held++;
			end
			r.count = count_t'(held);
			if (held == 0)
				r.median = '0;
			else if (held % 2 == 1)
				r.median = median_t'(2 * longint'(ordered[held / 2]));
			else
				r.median = median_t'(longint'(ordered[held / 2 - 1]) +
					longint'(ordered[held / 2]));
			expected_q = {expected_q, r};
		endfunction

		function void check_result(median_t m, count_t c);
			median_result_t r;
			if (expected_q.size() == 0) begin
				$error("result with none expected: median_doubled %0d, held_count %0d",
					m, c);
				failures++;
				return;
			end
			r = expected_q[0];
			expected_q.delete(0);
			if (m !== r.median) begin
				$error("median_doubled: expected %0d, actual %0d", r.median, m);
				failures++;
			end
			if (c !== r.count) begin
				$error("held_count: expected %0d, actual %0d", r.count, c);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	sample_t sample;
	logic out_valid;
	logic out_stall = 1'b0;
	median_t median_doubled;
	count_t held_count;
	logic cfg_valid;
	logic cfg_ready;
	count_t window_size;

	int idle_pct;
	int stall_pct;
	window_median_tracker tracker;

	sliding_window_median u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.median_doubled(median_doubled),
		.held_count(held_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.window_size(window_size)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(median_doubled, held_count);
	end

	task automatic send_sample(sample_t s);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_sample(s);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (tracker.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(count_t v);
		idle_input();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		window_size <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_window(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_burst(int n);
		sample_t s;
		sample_t last;
		int pause_at;
		last = '0;
		pause_at = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				idle_input();
				drain();
			end
			case ($urandom_range(9))
				0, 1, 2, 3: s = sample_t'($urandom);
				4, 5, 6: s = sample_t'(int'($urandom_range(10)) - 5);
				7: s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
				default: s = last + sample_t'(int'($urandom_range(6)) - 3);
			endcase
			send_sample(s);
			last = s;
		end
	endtask

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int idle_set[4];
		int stall_set[4];
		count_t win_list[8];
		count_t win;
		idle_set = '{0, 66, 0, 29};
		stall_set = '{0, 0, 66, 29};
		win_list = '{7'd64, 7'd3, 7'd127, 7'd1, 7'd0, 7'd9, 7'd64, 7'd2};
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		window_size = '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(32'sd0);
		send_sample(-32'sd1);
		send_sample(32'sd7);
		send_sample(32'sd7);
		send_sample(32'sd7);
		write_window(7'd0);
		send_sample(32'sd5);
		send_sample(-32'sd5);
		send_sample(32'sd5);
		write_window(7'd2);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MAX);
		send_sample(-32'sd1);
		write_window(7'd127);
		send_sample(32'sd3);
		send_sample(32'sd3);
		send_sample(-32'sd3);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		write_window(7'd1);
		send_sample(32'sd9);
		send_sample(SAMPLE_MIN);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			for (int k = 0; k < 2; k++) begin
				win = win_list[ph * 2 + k];
				if ((ph * 2 + k) % 3 == 2)
					win = count_t'($urandom_range(127));
				write_window(win);
				run_burst(75);
			end
		end

		idle_input();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
